[rtl/core/gpad_pkg.sv]
`timescale 1ns / 1ps

package gpad_pkg;

	// Input item kinds carried in the mode field.
	localparam logic [1:0] MODE_AXIS = 2'd0;
	localparam logic [1:0] MODE_KEY  = 2'd1;
	localparam logic [1:0] MODE_CMD  = 2'd2;

	// Result kinds carried in the event_kind field.
	localparam logic [1:0] EV_AXIS = 2'd0;
	localparam logic [1:0] EV_KEY  = 2'd1;
	localparam logic [1:0] EV_SYNC = 2'd2;

	localparam int KIND_W  = 2;
	localparam int CODE_W  = 10;
	localparam int VALUE_W = 16;
	localparam int KVAL_W  = 2;

	// Packed result: kind, code, value, padded to whole bytes.
	localparam int OUT_FIELDS_W = KIND_W + CODE_W + VALUE_W;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;
	localparam int unsigned CFG_RST_RAW = 2048;

	// The scaled magnitude never exceeds 32767, so fifteen quotient bits suffice.
	localparam int QUOT_BITS = 15;
	localparam int QCNT_W    = $clog2(QUOT_BITS);

	localparam int TABLE_SIZE = 14;

	localparam logic [CODE_W-1:0] REMAP_SRC [TABLE_SIZE] = '{
		10'h131, 10'h130, 10'h133, 10'h134, 10'h136, 10'h137, 10'h138,
		10'h139, 10'h2c5, 10'h2c0, 10'h220, 10'h221, 10'h222, 10'h223
	};

	localparam logic [CODE_W-1:0] REMAP_DST [TABLE_SIZE] = '{
		10'h130, 10'h131, 10'h134, 10'h133, 10'h136, 10'h137, 10'h138,
		10'h139, 10'h13b, 10'h13a, 10'h220, 10'h221, 10'h222, 10'h223
	};

	// Output axis codes indexed by {stick, vertical}: X, Y, RX, RY.
	localparam logic [CODE_W-1:0] AXIS_CODE [4] = '{10'd0, 10'd1, 10'd3, 10'd4};

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_PREP,
		SC_NUM,
		SC_MULT,
		SC_DIV,
		SC_DONE
	} scl_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scl_stat_t;

endpackage

[rtl/core/gamepad_axis_deadzone_and_button_remap.sv]
`timescale 1ns / 1ps

// Stick dead zone and button remap. Each input transfer is an axis sample, a button event
// or a forwarding command. While forwarding is on, an axis sample is taken relative to its
// programmed center, clamped to the half span (zero counts as one), inverted on vertical
// axes, passed through a 15 percent dead zone and scaled to -32767..32767; it yields an
// axis event followed by a sync report that carries tlast. A button code found in the
// built-in remap table yields a key event with the mapped code, then a sync report.
// Unknown codes and anything that arrives while forwarding is off yield nothing. An axis
// sample occupies the block from its transfer until the next input can be taken: setup
// steps, a one-bit-per-cycle restoring divider (skipped inside the dead zone) that produces
// the scaled magnitude, and a step to hand the pair of results to the output register. The
// output register holds one pair of results, so a new input is taken while that pair still
// waits downstream; a finished axis result waits in the divider until the output register
// is free.
module gamepad_axis_deadzone_and_button_remap #(
	parameter int SAMPLE_BITS   = 12,
	parameter int REMAP_ENTRIES = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_we,
	input  logic [gpad_pkg::REG_IDX_W-1:0]   cfg_addr,
	input  logic [SAMPLE_BITS-1:0]           cfg_wdata,

	input  logic                             s_tvalid,
	output logic                             s_tready,
	// From bit 0: mode, stick_select, axis_select, axis_value, key_code,
	// key_value, enable, zero padding.
	input  logic [((SAMPLE_BITS+17+7)/8)*8-1:0] s_tdata,

	output logic                             m_tvalid,
	input  logic                             m_tready,
	// From bit 0: event_kind, event_code, event_value, zero padding.
	output logic [gpad_pkg::OUT_W-1:0]       m_tdata,
	output logic                             m_tlast
);

	localparam int S        = SAMPLE_BITS;
	localparam int CODE_W   = gpad_pkg::CODE_W;
	localparam int VALUE_W  = gpad_pkg::VALUE_W;
	localparam int KV_LSB   = 4 + S + CODE_W;
	localparam int EN_BIT   = KV_LSB + gpad_pkg::KVAL_W;
	localparam logic [S-1:0] CFG_RST = S'(gpad_pkg::CFG_RST_RAW);

	// Unpacked input fields.
	logic [1:0]              in_mode;
	logic                    in_stick, in_vert, in_enable;
	logic [S-1:0]            in_sample;
	logic [CODE_W-1:0]       in_code;
	logic [gpad_pkg::KVAL_W-1:0] in_kval;

	assign in_mode   = s_tdata[1:0];
	assign in_stick  = s_tdata[2];
	assign in_vert   = s_tdata[3];
	assign in_sample = s_tdata[4 +: S];
	assign in_code   = s_tdata[4 + S +: CODE_W];
	assign in_kval   = s_tdata[KV_LSB +: gpad_pkg::KVAL_W];
	assign in_enable = s_tdata[EN_BIT];

	logic [S-1:0] cfg_q [gpad_pkg::NUM_REGS];
	logic         fwd_q;

	// Pending key event, waiting for the output register.
	logic              key_pend_q;
	logic [CODE_W-1:0] kp_code_q;
	logic [gpad_pkg::KVAL_W-1:0] kp_val_q;
	logic [CODE_W-1:0] ax_code_q;

	// Output register: one event and its sync report.
	logic               pair_vld_q, phase_q;
	logic [1:0]         ev_kind_q;
	logic [CODE_W-1:0]  ev_code_q;
	logic [VALUE_W-1:0] ev_val_q;

	gpad_pkg::scl_stat_t  scl_stat;
	logic [VALUE_W-1:0]   scl_value;
	logic [1:0]           sel;
	logic                 in_xfer, axis_start, key_hit, buf_free, load_key, load_axis;
	logic [CODE_W-1:0]    key_dst;

	assign sel        = {in_stick, in_vert};
	assign s_tready   = !scl_stat.busy && !key_pend_q;
	assign in_xfer    = s_tvalid && s_tready;
	assign axis_start = in_xfer && fwd_q && (in_mode == gpad_pkg::MODE_AXIS);

	// The lowest table entry that matches wins.
	always_comb begin
		key_hit = 1'b0;
		key_dst = '0;
		for (int i = gpad_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
			if (i < REMAP_ENTRIES && in_code == gpad_pkg::REMAP_SRC[i]) begin
				key_hit = 1'b1;
				key_dst = gpad_pkg::REMAP_DST[i];
			end
		end
	end

	// The output register can take a new pair once the sync report leaves.
	assign buf_free  = !pair_vld_q || (phase_q && m_tready);
	assign load_key  = key_pend_q && buf_free;
	assign load_axis = scl_stat.done && buf_free;

	gpad_axis_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (axis_start),
		.ack      (load_axis),
		.sample   (in_sample),
		.center   (cfg_q[{sel, 1'b0}]),
		.span     (cfg_q[{sel, 1'b1}]),
		.vertical (in_vert),
		.stat     (scl_stat),
		.value    (scl_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gpad_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= CFG_RST;
			end
		end else if (cfg_we) begin
			cfg_q[cfg_addr] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q      <= 1'b0;
			key_pend_q <= 1'b0;
			pair_vld_q <= 1'b0;
			phase_q    <= 1'b0;
		end else begin
			if (in_xfer && in_mode == gpad_pkg::MODE_CMD) begin
				fwd_q <= in_enable;
			end
			if (in_xfer && fwd_q && in_mode == gpad_pkg::MODE_KEY && key_hit) begin
				key_pend_q <= 1'b1;
			end else if (load_key) begin
				key_pend_q <= 1'b0;
			end
			if (load_key || load_axis) begin
				pair_vld_q <= 1'b1;
				phase_q    <= 1'b0;
			end else if (pair_vld_q && m_tready) begin
				if (phase_q) begin
					pair_vld_q <= 1'b0;
					phase_q    <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kp_code_q <= key_dst;
			kp_val_q  <= in_kval;
			ax_code_q <= gpad_pkg::AXIS_CODE[sel];
		end
		if (load_key) begin
			ev_kind_q <= gpad_pkg::EV_KEY;
			ev_code_q <= kp_code_q;
			ev_val_q  <= {{(VALUE_W - gpad_pkg::KVAL_W){1'b0}}, kp_val_q};
		end else if (load_axis) begin
			ev_kind_q <= gpad_pkg::EV_AXIS;
			ev_code_q <= ax_code_q;
			ev_val_q  <= scl_value;
		end
	end

	// The second half of each pair is the sync report with zero code and value.
	assign m_tvalid = pair_vld_q;
	assign m_tlast  = phase_q;
	always_comb begin
		if (phase_q) begin
			m_tdata = {{(gpad_pkg::OUT_W - gpad_pkg::OUT_FIELDS_W){1'b0}},
				{VALUE_W{1'b0}}, {CODE_W{1'b0}}, gpad_pkg::EV_SYNC};
		end else begin
			m_tdata = {{(gpad_pkg::OUT_W - gpad_pkg::OUT_FIELDS_W){1'b0}},
				ev_val_q, ev_code_q, ev_kind_q};
		end
	end

endmodule

[rtl/core/gpad_axis_scale.sv]
`timescale 1ns / 1ps

module gpad_axis_scale #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            ack,
	input  logic [SAMPLE_BITS-1:0]          sample,
	input  logic [SAMPLE_BITS-1:0]          center,
	input  logic [SAMPLE_BITS-1:0]          span,
	input  logic                            vertical,
	output gpad_pkg::scl_stat_t             stat,
	output logic [gpad_pkg::VALUE_W-1:0]    value
);

	localparam int S   = SAMPLE_BITS;
	localparam int QB  = gpad_pkg::QUOT_BITS;
	localparam int NW  = S + 5;
	localparam int PW  = NW + QB;

	gpad_pkg::scl_state_t state_q, state_d;

	logic [S-1:0]  samp_q, cent_q, h_q, a_q;
	logic          vert_q, neg_q, zero_q;
	logic [NW-1:0] num_q, den_q, rem_q;
	logic [QB-1:0] nlo_q, quot_q;
	logic [gpad_pkg::QCNT_W-1:0] cnt_q;

	logic [S-1:0]  diff;
	logic [NW-1:0] a_ext, h_ext, t20, t3;
	logic [PW-1:0] num_ext, prod;
	logic [NW:0]   r2, r2_sub;
	logic          r2_ge;

	always_comb begin
		diff    = (samp_q < cent_q) ? (cent_q - samp_q) : (samp_q - cent_q);
		a_ext   = {5'd0, a_q};
		h_ext   = {5'd0, h_q};
		t20     = (a_ext << 4) + (a_ext << 2);
		t3      = (h_ext << 1) + h_ext;
		num_ext = {{QB{1'b0}}, num_q};
		// Multiply by 32767 as a shift and one subtraction.
		prod    = (num_ext << QB) - num_ext;
		r2      = {rem_q, nlo_q[QB-1]};
		r2_ge   = r2 >= {1'b0, den_q};
		r2_sub  = r2 - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpad_pkg::SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gpad_pkg::SC_IDLE: begin
				samp_q <= sample;
				cent_q <= center;
				h_q    <= (span == '0) ? S'(1) : span;
				vert_q <= vertical;
			end
			gpad_pkg::SC_PREP: begin
				neg_q <= samp_q < cent_q;
				a_q   <= (diff > h_q) ? h_q : diff;
			end
			gpad_pkg::SC_NUM: begin
				zero_q <= t20 < t3;
				num_q  <= t20 - t3;
				den_q  <= (h_ext << 4) + h_ext;
			end
			gpad_pkg::SC_MULT: begin
				// The quotient fits in fifteen bits, so the upper part of the
				// product is already below the divisor.
				rem_q  <= prod[PW-1:QB];
				nlo_q  <= prod[QB-1:0];
				quot_q <= '0;
				cnt_q  <= '0;
			end
			gpad_pkg::SC_DIV: begin
				rem_q  <= r2_ge ? r2_sub[NW-1:0] : r2[NW-1:0];
				nlo_q  <= {nlo_q[QB-2:0], 1'b0};
				quot_q <= {quot_q[QB-2:0], r2_ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			gpad_pkg::SC_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gpad_pkg::SC_IDLE: if (start) state_d = gpad_pkg::SC_PREP;
			gpad_pkg::SC_PREP: state_d = gpad_pkg::SC_NUM;
			gpad_pkg::SC_NUM:  state_d = gpad_pkg::SC_MULT;
			gpad_pkg::SC_MULT: state_d = zero_q ? gpad_pkg::SC_DONE : gpad_pkg::SC_DIV;
			gpad_pkg::SC_DIV: begin
				if (cnt_q == gpad_pkg::QCNT_W'(QB - 1)) state_d = gpad_pkg::SC_DONE;
			end
			gpad_pkg::SC_DONE: if (ack) state_d = gpad_pkg::SC_IDLE;
			default: state_d = gpad_pkg::SC_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = state_q != gpad_pkg::SC_IDLE;
		stat.done = state_q == gpad_pkg::SC_DONE;
		// A zero result keeps the quotient at zero, so negation is harmless.
		if (neg_q ^ vert_q) begin
			value = gpad_pkg::VALUE_W'(0) - {1'b0, quot_q};
		end else begin
			value = {1'b0, quot_q};
		end
	end

endmodule

[rtl/core/gpad_checker.sv]
`timescale 1ns / 1ps

module gpad_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [gpad_pkg::OUT_W-1:0] m_tdata,
	input logic                       m_tlast
);

	// A stalled result holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// The run-ending result is always a sync report with zero code and value.
	a_last_is_sync: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[1:0] == gpad_pkg::EV_SYNC &&
			m_tdata[gpad_pkg::OUT_W-1:2] == '0)
		else $error("last result is not a clean sync report");

	// An event that is not last is never a sync report.
	a_event_not_sync: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[1:0] != gpad_pkg::EV_SYNC)
		else $error("sync report without tlast");

	// Every event is followed at once by its sync report.
	a_sync_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
		else $error("event not followed by sync report");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result offered during reset");

endmodule

bind gamepad_axis_deadzone_and_button_remap gpad_checker u_gpad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
